>>> design/slc_pkg.sv
// Shared types, codes and constants for the sound log command parser.
package slc_pkg;

   // Playback sample rate and the two fixed frame waits derived from it
   localparam int unsigned MixRate = 44100;
   localparam logic [15:0] Wait60Hz = 16'(MixRate / 60);
   localparam logic [15:0] Wait50Hz = 16'(MixRate / 50);

   // Command opcodes
   localparam logic [7:0] OpWait16  = 8'h61;
   localparam logic [7:0] OpWait60  = 8'h62;
   localparam logic [7:0] OpWait50  = 8'h63;
   localparam logic [7:0] OpEnd     = 8'h66;
   localparam logic [7:0] OpBlock   = 8'h67;
   localparam logic [7:0] OpReg0    = 8'h52;
   localparam logic [7:0] OpReg1    = 8'h53;
   localparam logic [7:0] OpReg2    = 8'h54;
   localparam logic [7:0] OpReg3    = 8'h55;
   localparam logic [7:0] OpReg4    = 8'hB0;
   localparam logic [7:0] OpReg5    = 8'hB3;
   localparam logic [7:0] OpReg6    = 8'hBF;
   localparam logic [3:0] OpWaitNib = 4'h7;

   // Data block types
   localparam logic [7:0] BlkPcm = 8'hC0;
   localparam logic [7:0] BlkRom = 8'h93;

   // Sound targets used by memory writes
   localparam logic [2:0] TgtPcm = 3'd4;
   localparam logic [2:0] TgtRom = 3'd6;

   // Config register indexes
   localparam logic CsrLoopOffset = 1'b0;
   localparam logic CsrLoopCount  = 1'b1;

   typedef enum logic [2:0] {
      EV_REG   = 3'd0,
      EV_MEM   = 3'd1,
      EV_WAIT  = 3'd2,
      EV_SEEK  = 3'd3,
      EV_DONE  = 3'd4,
      EV_ERROR = 3'd5
   } ev_kind_type;

   typedef enum logic [3:0] {
      PH_OPCODE,
      PH_REG_ADDR,
      PH_REG_DATA,
      PH_WAIT_LO,
      PH_WAIT_HI,
      PH_BLK_MARK,
      PH_BLK_TYPE,
      PH_BLK_SIZE,
      PH_PCM_ADDR0,
      PH_PCM_ADDR1,
      PH_ROM_SIZE,
      PH_ROM_ADDR,
      PH_PAYLOAD,
      PH_SKIP
   } phase_type;

   typedef struct packed {
      ev_kind_type kind;
      logic [2:0]  target;
      logic [31:0] address;
      logic [7:0]  data;
      logic [15:0] wait_samples;
   } event_type;

   // Register write opcode to sound target
   function automatic logic [2:0] reg_target(input logic [7:0] op);
      logic [2:0] tgt;
      case (op)
         OpReg0:  tgt = 3'd0;
         OpReg1:  tgt = 3'd1;
         OpReg2:  tgt = 3'd2;
         OpReg3:  tgt = 3'd3;
         OpReg4:  tgt = 3'd4;
         OpReg5:  tgt = 3'd5;
         default: tgt = 3'd6;
      endcase
      return tgt;
   endfunction

endpackage

>>> design/slc_parser.sv
// Byte-at-a-time command decoder: parser state registers and event generation.
module slc_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [31:0]         csr_wdata,
   input  logic                byte_valid,
   input  logic [7:0]          stream_byte,
   output logic                ev_valid,
   output slc_pkg::event_type  ev
);
   import slc_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [1:0]  sub_ff, sub_in;
   logic [7:0]  opcode_ff, opcode_in;
   logic [7:0]  held_ff, held_in;
   logic [7:0]  blk_type_ff, blk_type_in;
   logic [31:0] bytes_left_ff, bytes_left_in;
   logic [31:0] mem_addr_ff, mem_addr_in;
   logic [7:0]  loops_left_ff, loops_left_in;
   logic [31:0] resume_offset_ff, resume_offset_in;
   logic        finished_ff, finished_in;

   logic [31:0] byte_lane;
   logic [31:0] size_new;
   logic [31:0] rom_addr_new;

   // Current byte placed into the lane chosen by the sub counter
   assign byte_lane    = {24'b0, stream_byte} << {sub_ff, 3'b000};
   assign size_new     = bytes_left_ff | byte_lane;
   assign rom_addr_new = mem_addr_ff | byte_lane;

   // Next state and event
   always_comb begin
      phase_in         = phase_ff;
      sub_in           = sub_ff;
      opcode_in        = opcode_ff;
      held_in          = held_ff;
      blk_type_in      = blk_type_ff;
      bytes_left_in    = bytes_left_ff;
      mem_addr_in      = mem_addr_ff;
      loops_left_in    = loops_left_ff;
      resume_offset_in = resume_offset_ff;
      finished_in      = finished_ff;
      ev_valid         = 1'b0;
      ev               = '0;

      if (csr_we) begin
         if (csr_index == CsrLoopOffset) begin
            resume_offset_in = csr_wdata;
         end else begin
            loops_left_in = csr_wdata[7:0];
         end
      end else if (byte_valid && !finished_ff) begin
         case (phase_ff)
            PH_OPCODE: begin
               opcode_in = stream_byte;
               case (stream_byte)
                  OpReg0, OpReg1, OpReg2, OpReg3, OpReg4, OpReg5, OpReg6: begin
                     phase_in = PH_REG_ADDR;
                  end
                  OpBlock: begin
                     phase_in = PH_BLK_MARK;
                  end
                  OpWait16: begin
                     phase_in = PH_WAIT_LO;
                  end
                  OpWait60: begin
                     ev_valid        = 1'b1;
                     ev.kind         = EV_WAIT;
                     ev.wait_samples = Wait60Hz;
                  end
                  OpWait50: begin
                     ev_valid        = 1'b1;
                     ev.kind         = EV_WAIT;
                     ev.wait_samples = Wait50Hz;
                  end
                  OpEnd: begin
                     ev_valid = 1'b1;
                     if (resume_offset_ff != 32'd0 && loops_left_ff > 8'd1) begin
                        loops_left_in = loops_left_ff - 8'd1;
                        ev.kind       = EV_SEEK;
                        ev.address    = resume_offset_ff;
                     end else begin
                        finished_in = 1'b1;
                        ev.kind     = EV_DONE;
                     end
                  end
                  default: begin
                     ev_valid = 1'b1;
                     if (stream_byte[7:4] == OpWaitNib) begin
                        ev.kind         = EV_WAIT;
                        ev.wait_samples = {12'b0, stream_byte[3:0]} + 16'd1;
                     end else begin
                        // unknown opcode stops the parser
                        finished_in = 1'b1;
                        ev.kind     = EV_ERROR;
                        ev.data     = stream_byte;
                     end
                  end
               endcase
            end
            PH_REG_ADDR: begin
               held_in  = stream_byte;
               phase_in = PH_REG_DATA;
            end
            PH_REG_DATA: begin
               phase_in   = PH_OPCODE;
               ev_valid   = 1'b1;
               ev.kind    = EV_REG;
               ev.target  = reg_target(opcode_ff);
               ev.address = {24'b0, held_ff};
               ev.data    = stream_byte;
            end
            PH_WAIT_LO: begin
               held_in  = stream_byte;
               phase_in = PH_WAIT_HI;
            end
            PH_WAIT_HI: begin
               phase_in        = PH_OPCODE;
               ev_valid        = 1'b1;
               ev.kind         = EV_WAIT;
               ev.wait_samples = {stream_byte, held_ff};
            end
            PH_BLK_MARK: begin
               // marker byte is consumed unchecked
               phase_in = PH_BLK_TYPE;
            end
            PH_BLK_TYPE: begin
               blk_type_in   = stream_byte;
               bytes_left_in = '0;
               sub_in        = 2'd0;
               phase_in      = PH_BLK_SIZE;
            end
            PH_BLK_SIZE: begin
               bytes_left_in = size_new;
               sub_in        = sub_ff + 2'd1;
               if (sub_ff == 2'd3) begin
                  mem_addr_in = '0;
                  if (blk_type_ff == BlkPcm) begin
                     phase_in = PH_PCM_ADDR0;
                  end else if (blk_type_ff == BlkRom) begin
                     phase_in = PH_ROM_SIZE;
                  end else begin
                     phase_in = (size_new == 32'd0) ? PH_OPCODE : PH_SKIP;
                  end
               end
            end
            PH_PCM_ADDR0: begin
               mem_addr_in = {24'b0, stream_byte};
               phase_in    = PH_PCM_ADDR1;
            end
            PH_PCM_ADDR1: begin
               mem_addr_in = {16'b0, stream_byte, mem_addr_ff[7:0]};
               if (bytes_left_ff > 32'd2) begin
                  bytes_left_in = bytes_left_ff - 32'd2;
                  phase_in      = PH_PAYLOAD;
               end else begin
                  bytes_left_in = '0;
                  phase_in      = PH_OPCODE;
               end
            end
            PH_ROM_SIZE: begin
               // rom size field is read and dropped
               sub_in = sub_ff + 2'd1;
               if (sub_ff == 2'd3) begin
                  phase_in = PH_ROM_ADDR;
               end
            end
            PH_ROM_ADDR: begin
               mem_addr_in = rom_addr_new;
               sub_in      = sub_ff + 2'd1;
               if (sub_ff == 2'd3) begin
                  if (bytes_left_ff > 32'd8) begin
                     bytes_left_in = bytes_left_ff - 32'd8;
                     phase_in      = PH_PAYLOAD;
                  end else begin
                     bytes_left_in = '0;
                     phase_in      = PH_OPCODE;
                  end
               end
            end
            PH_PAYLOAD: begin
               ev_valid   = 1'b1;
               ev.kind    = EV_MEM;
               ev.address = mem_addr_ff;
               ev.data    = stream_byte;
               if (blk_type_ff == BlkPcm) begin
                  // pcm address wraps at 16 bits
                  ev.target   = TgtPcm;
                  mem_addr_in = {16'b0, mem_addr_ff[15:0] + 16'd1};
               end else begin
                  ev.target   = TgtRom;
                  mem_addr_in = mem_addr_ff + 32'd1;
               end
               bytes_left_in = bytes_left_ff - 32'd1;
               if (bytes_left_ff == 32'd1) begin
                  phase_in = PH_OPCODE;
               end
            end
            PH_SKIP: begin
               bytes_left_in = bytes_left_ff - 32'd1;
               if (bytes_left_ff == 32'd1) begin
                  phase_in = PH_OPCODE;
               end
            end
            default: begin
               phase_in = PH_OPCODE;
            end
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_OPCODE;
         sub_ff           <= 2'd0;
         opcode_ff        <= '0;
         held_ff          <= '0;
         blk_type_ff      <= '0;
         bytes_left_ff    <= '0;
         mem_addr_ff      <= '0;
         loops_left_ff    <= '0;
         resume_offset_ff <= '0;
         finished_ff      <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         sub_ff           <= sub_in;
         opcode_ff        <= opcode_in;
         held_ff          <= held_in;
         blk_type_ff      <= blk_type_in;
         bytes_left_ff    <= bytes_left_in;
         mem_addr_ff      <= mem_addr_in;
         loops_left_ff    <= loops_left_in;
         resume_offset_ff <= resume_offset_in;
         finished_ff      <= finished_in;
      end
   end

   // Once stopped, the parser stays stopped until reset
   a_finished_sticky: assert property (@(posedge clock) disable iff (reset)
      finished_ff |=> finished_ff)
      else $error("parser left the finished state without reset");

   // No event is produced after done or error
   a_no_event_when_finished: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> !ev_valid)
      else $error("event produced after parser finished");

   // Payload and skip phases always have bytes remaining
   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD || phase_ff == PH_SKIP) |-> bytes_left_ff != 32'd0)
      else $error("block phase with zero bytes left");

   // Events come only from an accepted byte
   a_event_needs_byte: assert property (@(posedge clock) disable iff (reset)
      ev_valid |-> byte_valid)
      else $error("event without an accepted byte");

endmodule

>>> design/slc_out_buf.sv
// Two-entry result buffer between the parser and the response channel.
module slc_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  slc_pkg::event_type  push_ev,
   output logic                not_full,
   output logic                out_valid,
   input  logic                out_ready,
   output slc_pkg::event_type  out_ev
);
   import slc_pkg::*;

   event_type  entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign out_valid = (count_ff != 2'd0);
   assign not_full  = (count_ff != 2'd2);
   assign out_ev    = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_ev;
      end
   end

   // Never written while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> not_full)
      else $error("result buffer overflow");

   // Fill count stays within the two entries
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count out of range");

   // Pointers differ exactly when one entry is held
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) == (wr_ptr_ff != rd_ptr_ff))
      else $error("result buffer pointers disagree with count");

endmodule

>>> design/sound_log_command_parser.sv
// Top level of the sound log command parser.
//
// Usage: command stream bytes enter on the req_ channel in file order, one
// transaction per byte. Each byte yields zero or one event on the rsp_
// channel: register write, memory write, wait, seek to loop, done or error.
// Events leave in byte order through a two-entry result buffer.
// An event enters the result buffer at its byte's transaction and shows on
// rsp_ once the events ahead of it have left. Throughput: one byte per cycle
// while req_ready is high; parser state is registered at each accepted byte.
// req_ready depends only on the buffer fill level; it drops when both buffer
// entries hold events, so a stalled receiver holds the stream back after two
// pending events. Bytes that produce no event still need a free entry.
// csr_ writes load the resume offset (index 0) and the play count (index 1);
// writing the play count reloads the remaining loop counter. Write them only
// when idle.
// Reset (synchronous, active high) returns the parser to opcode decode,
// clears both config registers and empties the result buffer. After a done
// or error event all further bytes are accepted and dropped until reset.
module sound_log_command_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_kind,
   output logic [2:0]  rsp_target,
   output logic [31:0] rsp_address,
   output logic [7:0]  rsp_data,
   output logic [15:0] rsp_wait_samples
);
   import slc_pkg::*;

   logic      req_accept;
   logic      buf_not_full;
   logic      ev_valid;
   event_type ev;
   event_type out_ev;

   assign req_ready  = buf_not_full;
   assign req_accept = req_valid && req_ready;

   slc_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .byte_valid  (req_accept),
      .stream_byte (req_stream_byte),
      .ev_valid    (ev_valid),
      .ev          (ev)
   );

   slc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_valid),
      .push_ev   (ev),
      .not_full  (buf_not_full),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_ev    (out_ev)
   );

   // Response fields
   assign rsp_event_kind   = out_ev.kind;
   assign rsp_target       = out_ev.target;
   assign rsp_address      = out_ev.address;
   assign rsp_data         = out_ev.data;
   assign rsp_wait_samples = out_ev.wait_samples;

endmodule

>>> verif/sound_log_command_parser_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sound log command parser, with its own stream decoder.
module sound_log_command_parser_tb;
   import slc_pkg::*;

   localparam int unsigned CycleLimit = 400000;

   // Register write opcodes, indexed by their sound target
   localparam logic [6:0][7:0] RegOpTable = {OpReg6, OpReg5, OpReg4, OpReg3,
                                             OpReg2, OpReg1, OpReg0};

   // Decoder state, config included
   typedef struct packed {
      phase_type   ph;
      logic [1:0]  step;
      logic [2:0]  reg_tgt;
      logic [7:0]  held;
      logic [7:0]  blk_type;
      logic [7:0]  loops_left;
      logic [31:0] remaining;
      logic [31:0] mem_addr;
      logic [31:0] resume_offset;
      logic        finished;
   } parse_state_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_index = CsrLoopOffset;
   logic [31:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_stream_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_event_kind;
   logic [2:0]  rsp_target;
   logic [31:0] rsp_address;
   logic [7:0]  rsp_data;
   logic [15:0] rsp_wait_samples;

   // gen_st tracks the stream as it is built, live_st as it is accepted
   parse_state_type gen_st = '0;
   parse_state_type live_st = '0;
   logic [7:0]      pending_bytes[$];
   event_type       expected_events[$];
   int unsigned     bytes_made = 0;
   int unsigned     send_idle_pct = 0;
   int unsigned     recv_stall_pct = 0;
   int unsigned     mismatch_count = 0;
   int unsigned     cycle_count = 0;

   sound_log_command_parser dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_stream_byte  (req_stream_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_target       (rsp_target),
      .rsp_address      (rsp_address),
      .rsp_data         (rsp_data),
      .rsp_wait_samples (rsp_wait_samples)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the decoder by one stream byte; fired is set when it yields an event
   function automatic void parse_byte(inout parse_state_type s, input logic [7:0] b,
                                      output bit fired, output event_type ev);
      bit is_reg;
      int i;
      fired = 1'b0;
      ev = '0;
      is_reg = 1'b0;
      if (s.finished) return;
      case (s.ph)
         PH_OPCODE: begin
            for (i = 0; i < 7; i++) begin
               if (b == RegOpTable[i]) begin
                  is_reg = 1'b1;
                  s.reg_tgt = 3'(i);
               end
            end
            if (is_reg) begin
               s.ph = PH_REG_ADDR;
            end else if (b == OpBlock) begin
               s.ph = PH_BLK_MARK;
            end else if (b == OpWait16) begin
               s.ph = PH_WAIT_LO;
            end else if (b == OpWait60 || b == OpWait50) begin
               fired = 1'b1;
               ev.kind = EV_WAIT;
               ev.wait_samples = (b == OpWait60) ? Wait60Hz : Wait50Hz;
            end else if (b == OpEnd) begin
               fired = 1'b1;
               if (s.resume_offset != 0 && s.loops_left > 8'd1) begin
                  s.loops_left = s.loops_left - 8'd1;
                  ev.kind = EV_SEEK;
                  ev.address = s.resume_offset;
               end else begin
                  s.finished = 1'b1;
                  ev.kind = EV_DONE;
               end
            end else if (b[7:4] == OpWaitNib) begin
               fired = 1'b1;
               ev.kind = EV_WAIT;
               ev.wait_samples = 16'(b[3:0]) + 16'd1;
            end else begin
               // unknown opcode stops the parser
               fired = 1'b1;
               s.finished = 1'b1;
               ev.kind = EV_ERROR;
               ev.data = b;
            end
         end
         PH_REG_ADDR: begin
            s.held = b;
            s.ph = PH_REG_DATA;
         end
         PH_REG_DATA: begin
            fired = 1'b1;
            ev.kind = EV_REG;
            ev.target = s.reg_tgt;
            ev.address = {24'h0, s.held};
            ev.data = b;
            s.ph = PH_OPCODE;
         end
         PH_WAIT_LO: begin
            s.held = b;
            s.ph = PH_WAIT_HI;
         end
         PH_WAIT_HI: begin
            fired = 1'b1;
            ev.kind = EV_WAIT;
            ev.wait_samples = {b, s.held};
            s.ph = PH_OPCODE;
         end
         PH_BLK_MARK: s.ph = PH_BLK_TYPE;
         PH_BLK_TYPE: begin
            s.blk_type = b;
            s.remaining = '0;
            s.step = 2'd0;
            s.ph = PH_BLK_SIZE;
         end
         // little-endian block size
         PH_BLK_SIZE: begin
            s.remaining = s.remaining | (32'(b) << (8 * s.step));
            if (s.step != 2'd3) begin
               s.step = s.step + 2'd1;
            end else if (s.blk_type == BlkPcm) begin
               s.mem_addr = '0;
               s.ph = PH_PCM_ADDR0;
            end else if (s.blk_type == BlkRom) begin
               s.mem_addr = '0;
               s.step = 2'd0;
               s.ph = PH_ROM_SIZE;
            end else begin
               s.ph = (s.remaining == 0) ? PH_OPCODE : PH_SKIP;
            end
         end
         PH_PCM_ADDR0: begin
            s.mem_addr = {24'h0, b};
            s.ph = PH_PCM_ADDR1;
         end
         PH_PCM_ADDR1: begin
            s.mem_addr = s.mem_addr | {16'h0, b, 8'h0};
            s.remaining = (s.remaining > 2) ? s.remaining - 2 : '0;
            s.ph = (s.remaining == 0) ? PH_OPCODE : PH_PAYLOAD;
         end
         // ROM size field is read and dropped
         PH_ROM_SIZE: begin
            if (s.step == 2'd3) begin
               s.step = 2'd0;
               s.ph = PH_ROM_ADDR;
            end else begin
               s.step = s.step + 2'd1;
            end
         end
         PH_ROM_ADDR: begin
            s.mem_addr = s.mem_addr | (32'(b) << (8 * s.step));
            if (s.step != 2'd3) begin
               s.step = s.step + 2'd1;
            end else begin
               s.remaining = (s.remaining > 8) ? s.remaining - 8 : '0;
               s.ph = (s.remaining == 0) ? PH_OPCODE : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            fired = 1'b1;
            ev.kind = EV_MEM;
            ev.address = s.mem_addr;
            ev.data = b;
            if (s.blk_type == BlkPcm) begin
               ev.target = TgtPcm;
               s.mem_addr = {16'h0, s.mem_addr[15:0] + 16'd1};
            end else begin
               ev.target = TgtRom;
               s.mem_addr = s.mem_addr + 32'd1;
            end
            s.remaining = s.remaining - 32'd1;
            if (s.remaining == 0) s.ph = PH_OPCODE;
         end
         PH_SKIP: begin
            s.remaining = s.remaining - 32'd1;
            if (s.remaining == 0) s.ph = PH_OPCODE;
         end
         default: s.ph = PH_OPCODE;
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < 50) $display("%0t mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // Queue a byte as is
   task automatic push_raw(input logic [7:0] b);
      bit fired;
      event_type ev;
      parse_byte(gen_st, b, fired, ev);
      pending_bytes.push_back(b);
      bytes_made++;
   endtask

   // Queue a byte, keeping block sizes short and the parser alive
   task automatic push_byte(input logic [7:0] b);
      parse_state_type trial;
      bit fired;
      event_type ev;
      logic [7:0] v;
      v = b;
      if (gen_st.ph == PH_BLK_SIZE && gen_st.step == 2'd1) v = v & 8'h01;
      else if (gen_st.ph == PH_BLK_SIZE && gen_st.step > 2'd1) v = 8'h00;
      trial = gen_st;
      parse_byte(trial, v, fired, ev);
      if (trial.finished) v = {OpWaitNib, 4'($urandom_range(15))};
      push_raw(v);
   endtask

   task automatic push_block(input logic [7:0] btype, input logic [31:0] sz,
                             input logic [31:0] addr);
      int unsigned payload;
      int i;
      push_byte(OpBlock);
      push_byte(8'($urandom_range(255)));
      push_byte(btype);
      for (i = 0; i < 4; i++) push_byte(sz[8*i +: 8]);
      payload = sz;
      if (btype == BlkPcm) begin
         push_byte(addr[7:0]);
         push_byte(addr[15:8]);
         payload = (sz > 2) ? sz - 2 : 0;
      end else if (btype == BlkRom) begin
         for (i = 0; i < 4; i++) push_byte(8'($urandom_range(255)));
         for (i = 0; i < 4; i++) push_byte(addr[8*i +: 8]);
         payload = (sz > 8) ? sz - 8 : 0;
      end
      repeat (payload) push_byte(8'($urandom_range(255)));
   endtask

   // One well-formed command with random content
   task automatic gen_command();
      int unsigned pick;
      logic [7:0] btype;
      logic [31:0] sz;
      logic [31:0] addr;
      pick = $urandom_range(99);
      if (pick < 30) begin
         push_byte(RegOpTable[$urandom_range(6)]);
         push_byte(8'($urandom_range(255)));
         push_byte(8'($urandom_range(255)));
      end else if (pick < 40) begin
         push_byte(OpWait16);
         if ($urandom_range(9) == 0) begin
            push_byte(8'h00);
            push_byte(8'h00);
         end else begin
            push_byte(8'($urandom_range(255)));
            push_byte(8'($urandom_range(255)));
         end
      end else if (pick < 46) begin
         push_byte($urandom_range(1) ? OpWait60 : OpWait50);
      end else if (pick < 56) begin
         push_byte({OpWaitNib, 4'($urandom_range(15))});
      end else if (pick < 62) begin
         // end marker only while it loops back
         if (gen_st.resume_offset != 0 && gen_st.loops_left > 8'd1) push_byte(OpEnd);
         else push_byte(OpWait60);
      end else begin
         pick = $urandom_range(99);
         if (pick < 45) btype = BlkPcm;
         else if (pick < 85) btype = BlkRom;
         else btype = 8'($urandom_range(255));
         sz = ($urandom_range(19) == 0) ? $urandom_range(300, 13) : $urandom_range(12);
         addr = $urandom;
         if ($urandom_range(3) == 0) addr = 32'hFFFF_FFFF - $urandom_range(3);
         push_block(btype, sz, addr);
      end
   endtask

   // Mostly commands, some stray bytes that break them up
   task automatic fill_random(input int unsigned n);
      int unsigned start;
      start = bytes_made;
      while (bytes_made - start < n) begin
         if (gen_st.ph != PH_OPCODE || $urandom_range(99) < 10)
            push_byte(8'($urandom_range(255)));
         else
            gen_command();
      end
      while (gen_st.ph != PH_OPCODE) push_byte(8'h00);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CsrLoopOffset) begin
         gen_st.resume_offset = val;
         live_st.resume_offset = val;
      end else begin
         gen_st.loops_left = val[7:0];
         live_st.loops_left = val[7:0];
      end
   endtask

   task automatic start_phase(input int unsigned idle, input int unsigned stall,
                              input logic [31:0] offset, input logic [7:0] count);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      write_csr(CsrLoopOffset, offset);
      write_csr(CsrLoopCount, {8'($urandom_range(255)), 16'($urandom_range(65535)), count});
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Drain the stream and all events, then let the pipeline settle
   task automatic wait_idle();
      while (pending_bytes.size() != 0 || req_valid || expected_events.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Byte driver; decodes each byte at its transaction
   always @(posedge clock) begin : drive_bytes
      bit fired;
      event_type ev;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            parse_byte(live_st, req_stream_byte, fired, ev);
            if (fired) expected_events.push_back(ev);
         end
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_stream_byte <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Event monitor
   always @(posedge clock) begin : check_events
      event_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               report_mismatch($sformatf("event kind %0d with none pending", rsp_event_kind));
            end else begin
               want = expected_events.pop_front();
               if (rsp_event_kind !== want.kind)
                  report_mismatch($sformatf("kind %0d, expected %0d", rsp_event_kind, want.kind));
               if (rsp_target !== want.target)
                  report_mismatch($sformatf("target %0d, expected %0d", rsp_target, want.target));
               if (rsp_address !== want.address)
                  report_mismatch($sformatf("address %h, expected %h", rsp_address, want.address));
               if (rsp_data !== want.data)
                  report_mismatch($sformatf("data %h, expected %h", rsp_data, want.data));
               if (rsp_wait_samples !== want.wait_samples)
                  report_mismatch($sformatf("wait %0d, expected %0d", rsp_wait_samples,
                                            want.wait_samples));
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("sound_log_command_parser_tb: done, errors");
         $finish;
      end
   end

   initial begin : stimulus
      logic [31:0] offset;
      logic [7:0] op;
      parse_state_type trial;
      bit fired;
      event_type ev;
      int i;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, every command, block corner cases
      start_phase(0, 0, 32'hFFFF_FFFF, 8'hFF);
      push_byte(OpReg0);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(OpReg6);
      push_byte(8'hFF);
      push_byte(8'h00);
      push_byte(OpWait16);
      push_byte(8'h00);
      push_byte(8'h00);
      push_byte(OpWait16);
      push_byte(8'hFF);
      push_byte(8'hFF);
      push_byte(OpWait60);
      push_byte(OpWait50);
      push_byte({OpWaitNib, 4'h0});
      push_byte({OpWaitNib, 4'hF});
      push_byte(OpEnd);
      push_block(BlkPcm, 32'd5, 32'h0000_FFFE);   // 16-bit address wrap
      push_block(BlkRom, 32'd10, 32'hFFFF_FFFF);  // 32-bit address wrap
      push_block(BlkPcm, 32'd2, 32'h0000_1234);   // header only
      push_block(BlkRom, 32'd8, $urandom);        // header only
      push_block(8'h5A, 32'd0, 32'h0);            // unknown type, empty
      push_block(8'h00, 32'd3, 32'h0);            // unknown type, skipped
      fill_random(300);
      wait_idle();

      start_phase(81, 0, 32'h0, 8'($urandom_range(254, 2)));
      fill_random(300);
      wait_idle();

      offset = $urandom;
      if (offset == 0) offset = 32'd1;
      start_phase(0, 81, offset, 8'h00);
      fill_random(300);
      wait_idle();

      start_phase(32, 32, $urandom, 8'($urandom_range(40, 3)));
      fill_random(250);
      wait_idle();

      // Closing: done through no offset, done through a low count, or an error
      offset = $urandom;
      if (offset == 0) offset = 32'd1;
      case ($urandom_range(2))
         0: begin
            start_phase(32, 32, 32'h0, 8'($urandom_range(255)));
            fill_random(40);
            push_raw(OpEnd);
         end
         1: begin
            start_phase(32, 32, offset, 8'($urandom_range(1)));
            fill_random(40);
            push_raw(OpEnd);
         end
         default: begin
            start_phase(32, 32, offset, 8'($urandom_range(255)));
            fill_random(40);
            do begin
               op = 8'($urandom_range(255));
               trial = gen_st;
               parse_byte(trial, op, fired, ev);
            end while (!(fired && ev.kind == EV_ERROR));
            push_raw(op);
         end
      endcase
      // everything after the stop is dropped
      for (i = 0; i < 16; i++) push_raw(8'($urandom_range(255)));
      wait_idle();
      repeat (6) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("sound_log_command_parser_tb: done, clean");
      end else begin
         $display("sound_log_command_parser_tb: done, errors");
      end
      $finish;
   end

endmodule
